// ===== design/lpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbm_pkg: shared definitions of the LRU page buffer manager
// Operation kinds, result status codes, the result record and the command
// and status records that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lpbm_pkg;

  localparam logic [2:0] KIND_FIX       = 3'd0;
  localparam logic [2:0] KIND_FIX_EMPTY = 3'd1;
  localparam logic [2:0] KIND_REF       = 3'd2;
  localparam logic [2:0] KIND_UNREF     = 3'd3;
  localparam logic [2:0] KIND_MARK      = 3'd4;
  localparam logic [2:0] KIND_INSPECT   = 3'd5;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_FRAME    = 3'd1;
  localparam logic [2:0] ST_STORE_FAIL  = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME   = 3'd3;
  localparam logic [2:0] ST_SATURATED   = 3'd4;

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [3:0]  frame;
    logic        writeback;
    logic [31:0] writeback_page;
    logic        fetch;
    logic [15:0] ref_count;
    logic        dirty;
    logic [31:0] frame_page;
  } res_t;

  typedef struct packed {
    logic load;         // latch an accepted request
    logic decode;       // settle results of malformed requests
    logic cnt_clr;
    logic cnt_inc;
    logic rd_cnt;       // frame RAM read address from the walk counter
    logic frame_op;     // reference, unreference, mark or inspect
    logic search_chk;   // compare one tag during the lookup
    logic pop_issue;    // read the top of the free stack
    logic pop_take;
    logic victim_chk;   // weigh one frame as replacement candidate
    logic victim_end;
    logic place;        // install the page in the chosen frame
    logic walk_op;      // close the recency gap left by the frame
    logic fin;          // write the frame's own metadata
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic kind_bad;
    logic kind_frame;
    logic kind_fix;
    logic idx_bad;
    logic cnt_last;
    logic match;
    logic refs_sat;
    logic free_empty;
    logic victim_none;
    logic victim_blocked;
    logic have_old;
    logic out_free;
  } sts_t;

endpackage

// ===== design/lpbm_req_if.sv =====
// ----------------------------------------------------------------------------
// lpbm_req_if: request channel
// Valid/ready channel carrying one page manager operation.
// ----------------------------------------------------------------------------
interface lpbm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] page_number;
  logic [7:0]  frame_index;

  modport source (output valid, kind, page_number, frame_index, input ready);
  modport sink   (input valid, kind, page_number, frame_index, output ready);
endinterface

// ===== design/lpbm_res_if.sv =====
// ----------------------------------------------------------------------------
// lpbm_res_if: result channel
// Valid/ready channel carrying the outcome of one operation.
// ----------------------------------------------------------------------------
interface lpbm_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit;
  logic [3:0]  frame;
  logic        writeback;
  logic [31:0] writeback_page;
  logic        fetch;
  logic [15:0] ref_count;
  logic        dirty;
  logic [31:0] frame_page;

  modport source (output valid, status, hit, frame, writeback, writeback_page, fetch,
                  ref_count, dirty, frame_page, input ready);
  modport sink   (input valid, status, hit, frame, writeback, writeback_page, fetch,
                  ref_count, dirty, frame_page, output ready);
endinterface

// ===== design/lpbm_ram.sv =====
// ----------------------------------------------------------------------------
// lpbm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lpbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpbm_ctrl: operation sequencer
// Steps each request through its frame operation, or through lookup, allocation
// and recency walk, and on to its result.
module lpbm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpbm_pkg::sts_t    sts,
  output lpbm_pkg::cmd_t    cmd
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_FRD    = 4'd2;
  localparam logic [3:0] S_FOP    = 4'd3;
  localparam logic [3:0] S_SRD    = 4'd4;
  localparam logic [3:0] S_SCK    = 4'd5;
  localparam logic [3:0] S_ALLOC  = 4'd6;
  localparam logic [3:0] S_POP    = 4'd7;
  localparam logic [3:0] S_VRD    = 4'd8;
  localparam logic [3:0] S_VCK    = 4'd9;
  localparam logic [3:0] S_VEND   = 4'd10;
  localparam logic [3:0] S_PLACE  = 4'd11;
  localparam logic [3:0] S_WRD    = 4'd12;
  localparam logic [3:0] S_WOP    = 4'd13;
  localparam logic [3:0] S_FIN    = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode  = 1'b1;
        cmd.cnt_clr = 1'b1;
        priority if (sts.kind_bad) begin
          state_nxt = S_DONE;
        end else if (sts.kind_frame) begin
          state_nxt = sts.idx_bad ? S_DONE : S_FRD;
        end else if (sts.kind_fix) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_ALLOC;
        end
      end
      S_FRD: begin
        state_nxt = S_FOP;
      end
      S_FOP: begin
        cmd.frame_op = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_SCK;
      end
      S_SCK: begin
        cmd.search_chk = 1'b1;
        if (sts.match) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = sts.refs_sat ? S_DONE : S_WRD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = sts.cnt_last ? S_ALLOC : S_SRD;
        end
      end
      S_ALLOC: begin
        if (sts.free_empty) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_VRD;
        end else begin
          cmd.pop_issue = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_take = 1'b1;
        state_nxt    = S_PLACE;
      end
      S_VRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_VCK;
      end
      S_VCK: begin
        cmd.victim_chk = 1'b1;
        cmd.cnt_inc    = 1'b1;
        state_nxt      = sts.cnt_last ? S_VEND : S_VRD;
      end
      S_VEND: begin
        cmd.victim_end = 1'b1;
        state_nxt = (sts.victim_none || sts.victim_blocked) ? S_DONE : S_PLACE;
      end
      S_PLACE: begin
        cmd.place   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = sts.have_old ? S_WRD : S_FIN;
      end
      S_WRD: begin
        cmd.rd_cnt = 1'b1;
        state_nxt  = S_WOP;
      end
      S_WOP: begin
        cmd.walk_op = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.cnt_last ? S_FIN : S_WRD;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== design/lpbm_dp.sv =====
// ----------------------------------------------------------------------------
// lpbm_dp: frame tables and result datapath
// Holds tags, metadata and the free stack in RAMs, with residency and
// counters in flip-flops, and carries out the sequencer's commands.
// ----------------------------------------------------------------------------
module lpbm_dp #(
  parameter int FRAMES = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_wdata,
  input  logic [2:0]              in_kind,
  input  logic [31:0]             in_page_number,
  input  logic [7:0]              in_frame_index,
  input  lpbm_pkg::cmd_t          cmd,
  output lpbm_pkg::sts_t          sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output lpbm_pkg::res_t          out_res
);
  localparam int IW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int MW = 17 + IW;

  logic              in_core_r;
  logic [2:0]        kind_r;
  logic [31:0]       page_r;
  logic [7:0]        idx_r;
  logic [FRAMES-1:0] used_r;
  logic [FRAMES-1:0] svalid_r;
  logic [CW-1:0]     fc_r;
  logic [CW-1:0]     count_r;
  logic [IW-1:0]     cnt_r;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     rd_addr_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     f_r;
  logic              have_old_r;
  logic [IW-1:0]     old_rank_r;
  logic [15:0]       refs_f_r;
  logic              dirty_f_r;
  logic [IW-1:0]     rank_f_r;
  logic              used_f_r;
  logic              best_v_r;
  logic [IW-1:0]     best_f_r;
  logic [IW-1:0]     best_rank_r;
  logic              best_dirty_r;
  logic [31:0]       best_tag_r;
  lpbm_pkg::res_t    res_r;
  lpbm_pkg::res_t    out_r;
  logic              out_valid_r;

  logic [31:0]   tag_q;
  logic [MW-1:0] meta_q;
  logic [IW-1:0] stack_q;
  logic          m_used;
  logic [15:0]   m_refs;
  logic          m_dirty;
  logic [IW-1:0] m_rank;
  logic [31:0]   m_tag;

  logic          meta_we;
  logic [IW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic          tag_we;
  logic          stack_we;

  logic          fo_we;
  logic [2:0]    fo_status;
  logic [15:0]   fo_refs;
  logic          fo_dirty;
  logic          walk_dec;
  logic          cand;
  logic          fail_fetch;
  logic [IW-1:0] pop_f;

  assign rd_addr = cmd.rd_cnt ? cnt_r : idx_r[IW-1:0];

  assign m_used  = used_r[rd_addr_r];
  assign m_refs  = m_used ? meta_q[MW-1 -: 16] : 16'd0;
  assign m_dirty = m_used & meta_q[IW];
  assign m_rank  = meta_q[IW-1:0];
  assign m_tag   = m_used ? tag_q : 32'd0;

  assign fail_fetch = (kind_r == lpbm_pkg::KIND_FIX) && in_core_r;
  assign pop_f      = svalid_r[pos_r] ? stack_q : pos_r;

  // Reference, unreference, mark and inspect on an in-range frame.
  always_comb begin
    fo_we     = 1'b0;
    fo_status = lpbm_pkg::ST_OK;
    fo_refs   = m_refs;
    fo_dirty  = m_dirty;
    priority if (kind_r != lpbm_pkg::KIND_INSPECT && m_refs == 16'd0) begin
      fo_status = lpbm_pkg::ST_BAD_FRAME;
    end else if (kind_r == lpbm_pkg::KIND_REF) begin
      if (m_refs == lpbm_pkg::REFS_MAX) begin
        fo_status = lpbm_pkg::ST_SATURATED;
      end else begin
        fo_refs = m_refs + 16'd1;
        fo_we   = 1'b1;
      end
    end else if (kind_r == lpbm_pkg::KIND_UNREF) begin
      fo_refs = m_refs - 16'd1;
      fo_we   = 1'b1;
    end else if (kind_r == lpbm_pkg::KIND_MARK) begin
      fo_dirty = 1'b1;
      fo_we    = 1'b1;
    end else begin
      fo_we = 1'b0;
    end
  end

  // Every resident frame ranked above the departing slot moves down by one.
  assign walk_dec = m_used && (rd_addr_r != f_r) && (m_rank > old_rank_r);
  assign cand     = m_used && (m_refs == 16'd0);

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = f_r;
    meta_wdata = {refs_f_r, dirty_f_r, rank_f_r};
    priority if (cmd.fin) begin
      meta_we = 1'b1;
    end else if (cmd.walk_op) begin
      meta_we    = walk_dec;
      meta_waddr = rd_addr_r;
      meta_wdata = {m_refs, m_dirty, m_rank - 1'b1};
    end else if (cmd.frame_op) begin
      meta_we    = fo_we;
      meta_waddr = rd_addr_r;
      meta_wdata = {fo_refs, fo_dirty, m_rank};
    end else begin
      meta_we = 1'b0;
    end
  end

  assign tag_we   = cmd.place;
  assign stack_we = cmd.place && fail_fetch && (fc_r < CW'(FRAMES));

  lpbm_ram #(.WIDTH(32), .DEPTH(FRAMES)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(f_r), .wdata(page_r),
    .raddr(rd_addr), .rdata(tag_q)
  );

  lpbm_ram #(.WIDTH(MW), .DEPTH(FRAMES)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(rd_addr), .rdata(meta_q)
  );

  lpbm_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_stack_ram (
    .clk(clk), .we(stack_we), .waddr(IW'(fc_r)), .wdata(f_r),
    .raddr(IW'(fc_r - 1'b1)), .rdata(stack_q)
  );

  always_comb begin
    sts.kind_bad       = (kind_r > lpbm_pkg::KIND_INSPECT);
    sts.kind_frame     = (kind_r >= lpbm_pkg::KIND_REF) && !sts.kind_bad;
    sts.kind_fix       = (kind_r == lpbm_pkg::KIND_FIX);
    sts.idx_bad        = ({1'b0, idx_r} >= 9'(FRAMES));
    sts.cnt_last       = (cnt_r == IW'(FRAMES - 1));
    sts.match          = m_used && (tag_q == page_r);
    sts.refs_sat       = (m_refs == lpbm_pkg::REFS_MAX);
    sts.free_empty     = (fc_r == '0);
    sts.victim_none    = !best_v_r;
    sts.victim_blocked = best_v_r && best_dirty_r && in_core_r;
    sts.have_old       = have_old_r;
    sts.out_free       = !out_valid_r || out_ready;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_core_r   <= 1'b0;
      used_r      <= '0;
      svalid_r    <= '0;
      fc_r        <= CW'(FRAMES);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        in_core_r <= cfg_wdata;
      end
      if (cmd.fin) begin
        used_r[f_r] <= used_f_r;
      end
      if (cmd.pop_issue) begin
        fc_r <= fc_r - 1'b1;
      end
      if (stack_we) begin
        svalid_r[IW'(fc_r)] <= 1'b1;
        fc_r                <= fc_r + 1'b1;
      end
      if (cmd.place) begin
        if (fail_fetch) begin
          count_r <= have_old_r ? count_r - 1'b1 : count_r;
        end else begin
          count_r <= have_old_r ? count_r : count_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-request working registers and the result record.
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    if (cmd.load) begin
      kind_r   <= in_kind;
      page_r   <= in_page_number;
      idx_r    <= in_frame_index;
      res_r    <= '0;
      best_v_r <= 1'b0;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.decode) begin
      if (sts.kind_bad) begin
        res_r.status <= lpbm_pkg::ST_BAD_FRAME;
      end else if (sts.kind_frame) begin
        res_r.frame <= idx_r[3:0];
        if (sts.idx_bad) begin
          res_r.status <= lpbm_pkg::ST_BAD_FRAME;
        end
      end
    end
    if (cmd.frame_op) begin
      res_r.status     <= fo_status;
      res_r.ref_count  <= fo_refs;
      res_r.dirty      <= fo_dirty;
      res_r.frame_page <= m_tag;
    end
    if (cmd.search_chk && sts.match) begin
      f_r              <= cnt_r;
      res_r.hit        <= 1'b1;
      res_r.frame      <= 4'(cnt_r);
      res_r.dirty      <= m_dirty;
      res_r.frame_page <= tag_q;
      have_old_r       <= 1'b1;
      old_rank_r       <= m_rank;
      refs_f_r         <= m_refs + 16'd1;
      dirty_f_r        <= m_dirty;
      rank_f_r         <= IW'(count_r - 1'b1);
      used_f_r         <= 1'b1;
      if (sts.refs_sat) begin
        res_r.status    <= lpbm_pkg::ST_SATURATED;
        res_r.ref_count <= m_refs;
      end else begin
        res_r.ref_count <= m_refs + 16'd1;
      end
    end
    if (cmd.pop_issue) begin
      pos_r <= IW'(fc_r - 1'b1);
    end
    if (cmd.pop_take) begin
      f_r        <= pop_f;
      have_old_r <= 1'b0;
    end
    if (cmd.victim_chk && cand && (!best_v_r || m_rank < best_rank_r)) begin
      best_v_r     <= 1'b1;
      best_f_r     <= rd_addr_r;
      best_rank_r  <= m_rank;
      best_dirty_r <= m_dirty;
      best_tag_r   <= tag_q;
    end
    if (cmd.victim_end) begin
      priority if (!best_v_r) begin
        res_r.status <= lpbm_pkg::ST_NO_FRAME;
      end else if (best_dirty_r && in_core_r) begin
        res_r.status     <= lpbm_pkg::ST_STORE_FAIL;
        res_r.frame      <= 4'(best_f_r);
        res_r.dirty      <= 1'b1;
        res_r.frame_page <= best_tag_r;
      end else begin
        f_r                  <= best_f_r;
        have_old_r           <= 1'b1;
        old_rank_r           <= best_rank_r;
        res_r.writeback      <= best_dirty_r;
        res_r.writeback_page <= best_dirty_r ? best_tag_r : 32'd0;
      end
    end
    if (cmd.place) begin
      res_r.frame <= 4'(f_r);
      dirty_f_r   <= 1'b0;
      if (fail_fetch) begin
        // Without backing store the frame goes straight back to the free stack.
        refs_f_r         <= 16'd0;
        rank_f_r         <= '0;
        used_f_r         <= 1'b0;
        res_r.status     <= lpbm_pkg::ST_STORE_FAIL;
        res_r.ref_count  <= 16'd0;
        res_r.frame_page <= 32'd0;
      end else begin
        refs_f_r         <= 16'd1;
        rank_f_r         <= have_old_r ? IW'(count_r - 1'b1) : IW'(count_r);
        used_f_r         <= 1'b1;
        res_r.fetch      <= (kind_r == lpbm_pkg::KIND_FIX);
        res_r.ref_count  <= 16'd1;
        res_r.frame_page <= page_r;
      end
      res_r.dirty <= 1'b0;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef ASSERT_OFF
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(FRAMES))
    else $error("free stack count beyond frame count");
  a_resident_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ($countones(used_r) == 32'(count_r)))
    else $error("recency list length disagrees with resident frames");
  a_frames_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> ((32'(count_r) + 32'(fc_r)) <= FRAMES))
    else $error("resident and free frames exceed frame count");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_issue |-> (fc_r != '0))
    else $error("pop from empty free stack");
`endif
endmodule

// ===== design/lru_page_buffer_manager_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_buffer_manager_top: LRU page frame manager
// Fixes pages into frames with LRU replacement and a free-frame stack, and
// references, unreferences, marks or inspects frames.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  in_req    sink       valid / ready    kind, page_number, frame_index
//  out_res   source     valid / ready    status .. frame_page (one per request)
//  cfg_*     sink       cfg_we           cfg_wdata = in_core
//
// Reference, unreference, mark and inspect read and act on one frame's metadata.
// A fix walks the tag RAM one frame at a time until it hits; a miss that
// finds the free stack empty scans all frames again for the victim, and a hit
// or eviction walks the metadata RAM once more to close the recency order;
// every walk reads one frame at a time, as each RAM has a single read port.
// Reset is synchronous and needs no clearing pass; one request is in flight
// at a time, and a stalled result holds the block in its final state.
// ----------------------------------------------------------------------------
module lru_page_buffer_manager_top #(
  parameter int FRAMES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  lpbm_req_if.sink  in_req,
  lpbm_res_if.source out_res
);
  lpbm_pkg::cmd_t cmd;
  lpbm_pkg::sts_t sts;
  lpbm_pkg::res_t res;
  logic           in_ready;

  lpbm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  lpbm_dp #(.FRAMES(FRAMES)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_kind(in_req.kind), .in_page_number(in_req.page_number),
    .in_frame_index(in_req.frame_index),
    .cmd(cmd), .sts(sts),
    .out_ready(out_res.ready), .out_valid(out_res.valid), .out_res(res)
  );

  assign in_req.ready           = in_ready;
  assign out_res.status         = res.status;
  assign out_res.hit            = res.hit;
  assign out_res.frame          = res.frame;
  assign out_res.writeback      = res.writeback;
  assign out_res.writeback_page = res.writeback_page;
  assign out_res.fetch          = res.fetch;
  assign out_res.ref_count      = res.ref_count;
  assign out_res.dirty          = res.dirty;
  assign out_res.frame_page     = res.frame_page;
endmodule
